// File: rtl/dcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_pkg
// shared constants and sequencer states of the divisor count and sum unit
// ----------------------------------------------------------------------------
package dcs_pkg;

    // default configuration
    localparam int DEF_INPUT_BITS  = 20;
    localparam int DEF_PRIME_LIMIT = 1024;

    // result widths and saturation limits
    localparam int COUNT_W = 8;
    localparam int SUM_W   = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 24'd16777215;

    // shared multiplier operand width
    localparam int MUL_W = 24;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEP = 4;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_SV_READ,
        ST_SV_CHECK,
        ST_SV_MARK,
        ST_IDLE,
        ST_FETCH,
        ST_FWAIT,
        ST_SQ,
        ST_DIV,
        ST_DIVEND,
        ST_POW,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_LEFT,
        ST_LEFT2,
        ST_LEFT3,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/dcs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dcs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/divisor_count_and_sum_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// divisor_count_and_sum_unit
// number of divisors and sum of divisors of one integer by trial division
// ----------------------------------------------------------------------------
// usage
//   a beat is taken at a rising edge with start high and busy low; i_n is the
//   integer to factor. the block then runs alone and holds busy high until
//   its result beat: o_valid is high for exactly one cycle with
//   o_divisor_count and o_divisor_sum, and busy drops in the cycle after.
//   the receiver cannot hold the result off, so nothing waits on it.
//   an input of zero returns zero in both fields.
// operation
//   each prime tried passes through fetch, square check, the divider and a
//   remainder check (one shared restoring divider, 4 quotient bits per cycle);
//   each further power of a found prime runs the divider again, each prime
//   found updates count and sum, and a final stop check and the tail close
//   the run. at the default width the worst case is a large prime input,
//   with all 172 primes tried.
// reset
//   after reset a clearing pass over all PRIME_LIMIT entries empties the sieve
//   marks, then the sieve fills the prime table; busy stays high until the
//   sieve is done, and only then is the first beat taken.
// ----------------------------------------------------------------------------
module divisor_count_and_sum_unit
    import dcs_pkg::*;
#(
    parameter int INPUT_BITS  = DEF_INPUT_BITS,
    parameter int PRIME_LIMIT = DEF_PRIME_LIMIT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic [INPUT_BITS-1:0] i_n,
    output logic                       busy,
    output logic                       o_valid,
    output logic [COUNT_W-1:0]         o_divisor_count,
    output logic [SUM_W-1:0]           o_divisor_sum
);

    // prime width, prime table depth (bound on primes below the limit)
    localparam int PW       = $clog2(PRIME_LIMIT);
    localparam int PT_DEPTH = PRIME_LIMIT / 2;
    localparam int PTW      = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int PCW      = PTW + 1;
    // divider geometry
    localparam int DIV_W    = ((INPUT_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_CYC  = DIV_W / DIV_STEP;
    localparam int DCW      = $clog2(DIV_CYC + 1);
    localparam int REM_W    = PW + 1;
    localparam int EW       = $clog2(INPUT_BITS + 2);
    localparam int RP_W     = INPUT_BITS + 1;
    localparam int PROD_W   = 2 * MUL_W;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [PROD_W-1:0] v);
        logic [SUM_W-1:0] res;
        res = (v > PROD_W'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_cnt(input logic [PROD_W-1:0] v);
        logic [COUNT_W-1:0] res;
        res = (v > PROD_W'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_W-1:0];
        return res;
    endfunction

    t_state r_state, n_state;

    // sieve control
    logic [PW-1:0]          r_i, n_i;
    logic [PW:0]            r_j, n_j;
    logic [PCW-1:0]         r_pcount, n_pcount;
    // factoring state
    logic [PCW-1:0]         r_k, n_k;
    logic [INPUT_BITS-1:0]  r_rest, n_rest;
    logic [PW-1:0]          r_p, n_p;
    logic [EW-1:0]          r_e, n_e;
    logic [SUM_W-1:0]       r_power, n_power;
    logic [SUM_W-1:0]       r_part, n_part;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [SUM_W-1:0]       r_sum, n_sum;
    // divider
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [DIV_W-1:0]       r_quot, n_quot;
    logic [DCW-1:0]         r_dcnt, n_dcnt;
    // shared multiplier
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      r_prod;

    // memories
    logic                   mark_we, mark_wd, mark_rd;
    logic [PW-1:0]          mark_wa, mark_ra;
    logic                   pt_we;
    logic [PW-1:0]          pt_rd;

    // helper terms
    logic                   sv_last, sv_prime, sv_mark_go, clr_last;
    logic [PW:0]            j_next;
    logic                   j_done;
    logic                   pt_end, sq_stop, div_last, div_exact;
    logic [RP_W-1:0]        rest_p1;
    logic [SUM_W-1:0]       rest_p1_sat;
    logic [SUM_W-1:0]       pow_sat;
    logic [SUM_W:0]         part_add;
    logic [REM_W-1:0]       d_rem;
    logic [DIV_W-1:0]       d_quot;

    dcs_ram #(
        .DATA_W (1),
        .DEPTH  (PRIME_LIMIT),
        .ADDR_W (PW)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mark_we),
        .i_wr_addr (mark_wa),
        .i_wr_data (mark_wd),
        .i_rd_addr (mark_ra),
        .o_rd_data (mark_rd)
    );

    dcs_ram #(
        .DATA_W (PW),
        .DEPTH  (PT_DEPTH),
        .ADDR_W (PTW)
    ) u_prime_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pt_we),
        .i_wr_addr (r_pcount[PTW-1:0]),
        .i_wr_data (r_i),
        .i_rd_addr (r_k[PTW-1:0]),
        .o_rd_data (pt_rd)
    );

    // helper terms
    always_comb begin
        clr_last    = (r_j == (PW+1)'(PRIME_LIMIT - 1));
        sv_last     = (r_i == PW'(PRIME_LIMIT - 1));
        sv_prime    = !mark_rd;
        // a fresh prime marks its multiples only while its square is in range
        sv_mark_go  = sv_prime && (r_prod < PROD_W'(PRIME_LIMIT));
        j_next      = r_j + (PW+1)'(r_i);
        j_done      = (j_next >= (PW+1)'(PRIME_LIMIT));
        pt_end      = (r_k == r_pcount);
        sq_stop     = (r_prod > PROD_W'(r_rest));
        div_last    = (r_dcnt == DCW'(DIV_CYC - 1));
        div_exact   = (r_rem == '0);
        rest_p1     = RP_W'(r_rest) + RP_W'(1);
        rest_p1_sat = (rest_p1 > RP_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(rest_p1);
        pow_sat     = sat_sum(r_prod);
        part_add    = (SUM_W+1)'(r_part) + (SUM_W+1)'(pow_sat);
    end

    // divider step: four restoring steps per cycle
    always_comb begin
        d_rem  = r_rem;
        d_quot = r_quot;
        for (int s = 0; s < DIV_STEP; s++) begin
            d_rem  = {d_rem[REM_W-2:0], d_quot[DIV_W-1]};
            d_quot = {d_quot[DIV_W-2:0], 1'b0};
            if (d_rem >= {1'b0, r_p}) begin
                d_rem     = d_rem - {1'b0, r_p};
                d_quot[0] = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (clr_last) n_state = ST_SV_READ;
            ST_SV_READ:  n_state = ST_SV_CHECK;
            ST_SV_CHECK: begin
                if (sv_mark_go) begin
                    n_state = ST_SV_MARK;
                end else begin
                    n_state = sv_last ? ST_IDLE : ST_SV_READ;
                end
            end
            ST_SV_MARK:  if (j_done) n_state = sv_last ? ST_IDLE : ST_SV_READ;
            ST_IDLE:     if (start) n_state = (i_n == '0) ? ST_DONE : ST_FETCH;
            ST_FETCH:    n_state = pt_end ? ST_LEFT : ST_FWAIT;
            ST_FWAIT:    n_state = ST_SQ;
            ST_SQ:       n_state = sq_stop ? ST_LEFT : ST_DIV;
            ST_DIV:      if (div_last) n_state = ST_DIVEND;
            ST_DIVEND:   n_state = div_exact ? ST_POW : ST_UPD1;
            ST_POW:      n_state = ST_DIV;
            ST_UPD1:     n_state = (r_e == '0) ? ST_FETCH : ST_UPD2;
            ST_UPD2:     n_state = ST_UPD3;
            ST_UPD3:     n_state = ST_FETCH;
            ST_LEFT:     n_state = (r_rest != INPUT_BITS'(1)) ? ST_LEFT2 : ST_DONE;
            ST_LEFT2:    n_state = ST_LEFT3;
            ST_LEFT3:    n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs, memory controls and multiplier operand select
    always_comb begin
        busy    = (r_state != ST_IDLE);
        o_valid = (r_state == ST_DONE);
        mark_we = 1'b0;
        mark_wd = 1'b0;
        mark_wa = r_j[PW-1:0];
        mark_ra = r_i;
        pt_we   = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ST_CLEAR: begin
                mark_we = 1'b1;
            end
            ST_SV_READ: begin
                mul_a = MUL_W'(r_i);
                mul_b = MUL_W'(r_i);
            end
            ST_SV_CHECK: begin
                pt_we = sv_prime;
            end
            ST_SV_MARK: begin
                mark_we = 1'b1;
                mark_wd = 1'b1;
            end
            ST_FWAIT: begin
                mul_a = MUL_W'(pt_rd);
                mul_b = MUL_W'(pt_rd);
            end
            ST_DIVEND: begin
                mul_a = MUL_W'(r_power);
                mul_b = MUL_W'(r_p);
            end
            ST_UPD1: begin
                mul_a = MUL_W'(r_count);
                mul_b = MUL_W'(r_e) + MUL_W'(1);
            end
            ST_UPD2: begin
                mul_a = MUL_W'(r_sum);
                mul_b = MUL_W'(r_part);
            end
            ST_LEFT: begin
                mul_a = MUL_W'(r_count);
                mul_b = MUL_W'(2);
            end
            ST_LEFT2: begin
                mul_a = MUL_W'(r_sum);
                mul_b = MUL_W'(rest_p1_sat);
            end
            default: begin
                mul_a = '0;
            end
        endcase
        o_divisor_count = r_count;
        o_divisor_sum   = r_sum;
    end

    // datapath next values
    always_comb begin
        n_i      = r_i;
        n_j      = r_j;
        n_pcount = r_pcount;
        n_k      = r_k;
        n_rest   = r_rest;
        n_p      = r_p;
        n_e      = r_e;
        n_power  = r_power;
        n_part   = r_part;
        n_count  = r_count;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_dcnt   = r_dcnt;
        case (r_state)
            ST_CLEAR: begin
                n_j = r_j + (PW+1)'(1);
                n_i = PW'(2);
            end
            ST_SV_CHECK: begin
                if (sv_prime) n_pcount = r_pcount + PCW'(1);
                if (sv_mark_go) begin
                    n_j = r_prod[PW:0];
                end else begin
                    n_i = r_i + PW'(1);
                end
            end
            ST_SV_MARK: begin
                n_j = j_next;
                if (j_done) n_i = r_i + PW'(1);
            end
            ST_IDLE: begin
                if (start) begin
                    n_rest = i_n;
                    n_k    = '0;
                    if (i_n == '0) begin
                        n_count = '0;
                        n_sum   = '0;
                    end else begin
                        n_count = COUNT_W'(1);
                        n_sum   = SUM_W'(1);
                    end
                end
            end
            ST_FWAIT: begin
                n_p = pt_rd;
            end
            ST_SQ: begin
                n_e     = '0;
                n_power = SUM_W'(1);
                n_part  = SUM_W'(1);
                n_rem   = '0;
                n_quot  = DIV_W'(r_rest);
                n_dcnt  = '0;
            end
            ST_DIV: begin
                n_rem  = d_rem;
                n_quot = d_quot;
                n_dcnt = r_dcnt + DCW'(1);
            end
            ST_DIVEND: begin
                if (div_exact) begin
                    n_rest = r_quot[INPUT_BITS-1:0];
                    n_e    = r_e + EW'(1);
                end
            end
            ST_POW: begin
                // power and partial sum saturate; the final sum does too
                n_power = pow_sat;
                n_part  = (part_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : part_add[SUM_W-1:0];
                n_rem   = '0;
                n_quot  = DIV_W'(r_rest);
                n_dcnt  = '0;
            end
            ST_UPD1: begin
                if (r_e == '0) n_k = r_k + PCW'(1);
            end
            ST_UPD2: begin
                n_count = sat_cnt(r_prod);
            end
            ST_UPD3: begin
                n_sum = sat_sum(r_prod);
                n_k   = r_k + PCW'(1);
            end
            ST_LEFT2: begin
                n_count = sat_cnt(r_prod);
            end
            ST_LEFT3: begin
                n_sum = sat_sum(r_prod);
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_i      <= '0;
            r_j      <= '0;
            r_pcount <= '0;
            r_k      <= '0;
            r_dcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_pcount <= n_pcount;
            r_k      <= n_k;
            r_dcnt   <= n_dcnt;
        end
        r_rest  <= n_rest;
        r_p     <= n_p;
        r_e     <= n_e;
        r_power <= n_power;
        r_part  <= n_part;
        r_count <= n_count;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_prod  <= mul_a * mul_b;
    end

    // a taken beat always starts a busy period
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("beat taken but unit not busy");

    // the result beat is part of the busy period and lasts one cycle
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy ##1 !busy))
        else $error("result beat outside busy period or held");

    // a zero count only ever marks a zero input, with a zero sum
    a_zero_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divisor_count == '0) |-> (o_divisor_sum == '0))
        else $error("zero count with nonzero sum");

    // trial division never reads beyond the filled part of the prime table
    a_table_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_k <= r_pcount))
        else $error("prime index beyond table fill");

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the divisor count and sum unit
// ----------------------------------------------------------------------------
// integers are fed through the start/busy handshake from a queue, and each
// accepted beat is scored by a local trial-division model. the monitor
// matches every result strobe against the oldest open prediction. the run
// has four idle profiles. it opens with the corner cases and then uses a
// random mix of smooth numbers, full-width and short-width values.
// ----------------------------------------------------------------------------
module testbench
    import dcs_pkg::*;
();

    localparam int          N_W         = DEF_INPUT_BITS;
    localparam int unsigned N_MAX       = (32'd1 << N_W) - 1;
    localparam int          RANDOM_BEATS = 850;
    localparam int          DRAIN_CYCLES = 2000;  // one worst-case item

    // one integer waiting to go out, with the idle odds of its phase
    typedef struct {
        logic [N_W-1:0] n;
        int unsigned    idle_pct;
    } t_pending_beat;

    // predicted result for one accepted integer
    typedef struct {
        logic [N_W-1:0]     n;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } t_divisor_stats;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [N_W-1:0]       i_n = '0;
    logic                 busy;
    logic                 o_valid;
    logic [COUNT_W-1:0]   o_divisor_count;
    logic [SUM_W-1:0]     o_divisor_sum;

    t_pending_beat        pending_n[$];
    t_divisor_stats       expected_stats[$];
    int unsigned          primes[$];
    int                   error_count = 0;
    int                   beats_taken = 0;
    int                   results_seen = 0;

    divisor_count_and_sum_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_n             (i_n),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_divisor_count (o_divisor_count),
        .o_divisor_sum   (o_divisor_sum)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // primes below the table limit, sieve of eratosthenes
    function automatic void build_primes();
        bit composite[DEF_PRIME_LIMIT];
        int unsigned j;
        for (int unsigned i = 2; i < DEF_PRIME_LIMIT; i++) begin
            if (!composite[i]) begin
                primes.insert(primes.size(), i);
                for (j = i * i; j < DEF_PRIME_LIMIT; j += i)
                    composite[j] = 1'b1;
            end
        end
    endfunction

    // d(n) and sigma(n) by trial division, saturated to the port widths
    function automatic t_divisor_stats divisor_stats(input logic [N_W-1:0] value);
        t_divisor_stats    res;
        longint unsigned   rest;
        longint unsigned   count;
        longint unsigned   total;
        longint unsigned   p;
        longint unsigned   power;
        longint unsigned   part;
        longint unsigned   e;
        res.n = value;
        rest  = value;
        count = 1;
        total = 1;
        // zero has no divisors worth naming, the block flags it with all zeros
        if (rest == 0) begin
            res.count = '0;
            res.sum   = '0;
            return res;
        end
        foreach (primes[k]) begin
            p = primes[k];
            if (p * p > rest)
                break;
            power = 1;
            part  = 1;
            e     = 0;
            while (rest % p == 0) begin
                rest  = rest / p;
                power = power * p;
                part  = part + power;
                e++;
            end
            count = count * (e + 1);
            total = total * part;
        end
        // anything left above one is a single large prime
        if (rest != 1) begin
            count = count * 2;
            total = total * (rest + 1);
        end
        res.count = (count > COUNT_MAX) ? COUNT_MAX : count[COUNT_W-1:0];
        res.sum   = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        return res;
    endfunction

    // random integer: smooth numbers drive the exponent loop, full-width
    // values drive long prime walks, short widths give cheaper items
    function automatic logic [N_W-1:0] random_n();
        int unsigned     pick;
        int unsigned     width;
        longint unsigned v;
        longint unsigned p;
        pick = $urandom_range(99);
        if (pick < 2)
            return '0;
        if (pick < 35)
            return N_W'($urandom_range(N_MAX, 1));
        if (pick < 60) begin
            width = $urandom_range(N_W, 1);
            return N_W'($urandom & ((32'd1 << width) - 1));
        end
        v = 1;
        repeat ($urandom_range(14, 1)) begin
            if ($urandom_range(3) != 0)
                p = primes[$urandom_range(5)];
            else
                p = primes[$urandom_range(primes.size() - 1)];
            if (v * p <= N_MAX)
                v = v * p;
        end
        // sometimes a random cofactor on top, often a prime above the table
        if ($urandom_range(3) == 0)
            v = v * $urandom_range(N_MAX / v, 1);
        return N_W'(v);
    endfunction

    // driver: holds start until the beat is taken, then rolls the idle odds
    // of the next item every cycle until it goes out
    always @(posedge i_clk) begin
        logic taken;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                expected_stats.insert(expected_stats.size(), divisor_stats(i_n));
                beats_taken++;
            end
            if (start && !taken) begin
                // beat still waiting on busy, keep it on the port
            end else if (pending_n.size() != 0 &&
                         $urandom_range(99) >= pending_n[0].idle_pct) begin
                start <= 1'b1;
                i_n   <= pending_n.pop_front().n;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_divisor_stats want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                $error("result beat with nothing pending: count %0d sum %0d",
                       o_divisor_count, o_divisor_sum);
                error_count++;
            end else begin
                want = expected_stats.pop_front();
                if (o_divisor_count !== want.count) begin
                    $error("divisor_count for n=%0d: expected %0d, actual %0d",
                           want.n, want.count, o_divisor_count);
                    error_count++;
                end
                if (o_divisor_sum !== want.sum) begin
                    $error("divisor_sum for n=%0d: expected %0d, actual %0d",
                           want.n, want.sum, o_divisor_sum);
                    error_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [N_W-1:0] corner_n[] = '{
            0, 1, 2, 3, 4, 6, 12,
            1048575,   // all ones, 3 * 5^2 * 11 * 31 * 41
            524288,    // top bit only, 2^19
            1048573,   // largest prime that fits
            1048574,   // 2 times a large mersenne prime
            1046529,   // 1023^2, repeated odd primes
            1042441,   // square of the last prime in the table
            1040399,   // two largest table primes
            720720,    // many divisors
            531441,    // 3^12, long exponent run
            349525,    // alternating bits
            699050,    // alternating bits, inverted
            1021,      // last table prime on its own
            1031       // first prime above the table
        };
        // sender idle percentage per phase; the result side cannot stall, so
        // phases 0 and 2 both run the sender flat out
        int unsigned phase_idle[4] = '{0, 81, 0, 27};

        build_primes();
        foreach (corner_n[i])
            pending_n.insert(pending_n.size(),
                             t_pending_beat'{n: corner_n[i], idle_pct: 0});
        foreach (phase_idle[ph])
            repeat (RANDOM_BEATS / 4)
                pending_n.insert(pending_n.size(),
                                 t_pending_beat'{n: random_n(), idle_pct: phase_idle[ph]});

        // reset first, then the block sieves on its own under busy
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_n.size() != 0 || start || expected_stats.size() != 0)
            @(posedge i_clk);
        // catch any stray strobe after the last result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("factored %0d integers, %0d result beats seen, %0d mismatches",
                 beats_taken, results_seen, error_count);
        if (error_count == 0 && expected_stats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(30_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
